// ----- design/segment_record_deframer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the segment record deframer
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define SEGMENT_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment record deframer package
// Shared result type and alignment constants.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

    localparam int unsigned BLK_LOG2 = 12;
    localparam int unsigned REC_LOG2 = 3;

    localparam logic [33:0] BLK_MASK = 34'((64'd1 << BLK_LOG2) - 64'd1);
    localparam logic [33:0] REC_MASK = 34'((64'd1 << REC_LOG2) - 64'd1);

    typedef struct packed {
        logic        truncated;
        logic        last_of_record;
        logic        first_of_record;
        logic [7:0]  payload_byte;
        logic [31:0] record_size;
        logic [25:0] record_start;
        logic [19:0] record_segment;
    } t_result;

endpackage

`default_nettype wire

// ----- design/srd_parser.sv -----
// ----------------------------------------------------------------------------
// Segment record deframer parser
// Tracks the position in the segment and the framing phase, and produces
// one result for each payload byte in the cycle the byte is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic [19:0]     i_segment_num,
    input  wire logic [26:0]     i_segment_size,
    output logic                 o_res_valid,
    output srd_pkg::t_result     o_res
);

    localparam logic [2:0] PH_BUF_HDR = 3'd0;
    localparam logic [2:0] PH_REC_HDR = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    logic [26:0] r_position,     n_position;
    logic [2:0]  r_phase,        n_phase;
    logic [23:0] r_hdr_shift,    n_hdr_shift;
    logic [1:0]  r_hdr_count,    n_hdr_count;
    logic [31:0] r_payload_left, n_payload_left;
    logic [25:0] r_cur_offset,   n_cur_offset;
    logic [31:0] r_cur_size,     n_cur_size;
    logic [33:0] r_skip_target,  n_skip_target;
    logic [33:0] r_buf_end,      n_buf_end;
    logic [33:0] r_buf_end_rnd;

    logic [27:0] np;
    logic [33:0] np_w;
    logic        seg_end;
    logic        hdr_done;
    logic [31:0] hdr_word;
    logic        np_blk_aligned;
    logic        np_rec_aligned;
    logic [33:0] np_blk_rnd;
    logic [33:0] np_rec_rnd;
    logic        in_buffer;
    logic        pay_first;
    logic        pay_last;
    logic        pay_trunc;

    always_comb begin
        np             = {1'b0, r_position} + 28'd1;
        np_w           = {6'd0, np};
        seg_end        = np >= {1'b0, i_segment_size};
        hdr_done       = r_hdr_count == 2'd3;
        hdr_word       = {i_data_byte, r_hdr_shift};
        np_blk_aligned = (np_w & srd_pkg::BLK_MASK) == 34'd0;
        np_rec_aligned = (np_w & srd_pkg::REC_MASK) == 34'd0;
        np_blk_rnd     = (np_w + srd_pkg::BLK_MASK) & ~srd_pkg::BLK_MASK;
        np_rec_rnd     = (np_w + srd_pkg::REC_MASK) & ~srd_pkg::REC_MASK;
        in_buffer      = np_w < r_buf_end;
        pay_first      = r_payload_left == r_cur_size;
        pay_last       = r_payload_left == 32'd1;
        pay_trunc      = !pay_last && seg_end;
    end

    // The bytes consumed in a buffer always equal the distance from the
    // buffer start at the points where they are compared, so the buffer end
    // position stands in for the length and the consumed count.
    always_comb begin
        n_position     = r_position;
        n_phase        = r_phase;
        n_hdr_shift    = r_hdr_shift;
        n_hdr_count    = r_hdr_count;
        n_payload_left = r_payload_left;
        n_cur_offset   = r_cur_offset;
        n_cur_size     = r_cur_size;
        n_skip_target  = r_skip_target;
        n_buf_end      = r_buf_end;
        o_res_valid    = 1'b0;

        o_res.record_segment  = i_segment_num;
        o_res.record_start    = r_cur_offset;
        o_res.record_size     = r_cur_size;
        o_res.payload_byte    = i_data_byte;
        o_res.first_of_record = pay_first;
        o_res.last_of_record  = pay_last || pay_trunc;
        o_res.truncated       = pay_trunc;

        if (i_accept) begin
            unique case (r_phase)
                PH_BUF_HDR, PH_REC_HDR: begin
                    if (hdr_done) begin
                        n_hdr_shift = 24'd0;
                        n_hdr_count = 2'd0;
                        if (r_phase == PH_BUF_HDR) begin
                            if (hdr_word == 32'd0) begin
                                n_skip_target = np_blk_rnd;
                                n_phase = np_blk_aligned ? PH_BUF_HDR : PH_SKIP;
                            end else begin
                                n_buf_end = np_w + {2'd0, hdr_word};
                                n_phase   = PH_REC_HDR;
                            end
                        end else if (hdr_word == 32'd0) begin
                            if (in_buffer) begin
                                n_skip_target = r_buf_end_rnd;
                                n_phase       = PH_SKIP;
                            end else if (np_blk_aligned) begin
                                n_phase = PH_BUF_HDR;
                            end else begin
                                n_skip_target = np_blk_rnd;
                                n_phase       = PH_SKIP;
                            end
                        end else begin
                            n_cur_offset   = np[25:0];
                            n_cur_size     = hdr_word;
                            n_payload_left = hdr_word;
                            n_phase        = PH_PAYLOAD;
                        end
                    end else begin
                        n_hdr_shift[{r_hdr_count, 3'b000} +: 8] = i_data_byte;
                        n_hdr_count = r_hdr_count + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid    = 1'b1;
                    n_payload_left = r_payload_left - 32'd1;
                    if (pay_last) begin
                        if (!np_rec_aligned) begin
                            n_skip_target = np_rec_rnd;
                            n_phase       = PH_PAD;
                        end else if (in_buffer) begin
                            n_phase = PH_REC_HDR;
                        end else if (np_blk_aligned) begin
                            n_phase = PH_BUF_HDR;
                        end else begin
                            n_skip_target = np_blk_rnd;
                            n_phase       = PH_SKIP;
                        end
                    end
                end
                PH_PAD: begin
                    if (np_w == r_skip_target) begin
                        if (in_buffer) begin
                            n_phase = PH_REC_HDR;
                        end else if (np_blk_aligned) begin
                            n_phase = PH_BUF_HDR;
                        end else begin
                            n_skip_target = np_blk_rnd;
                            n_phase       = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (np_w == r_skip_target) begin
                        n_phase = PH_BUF_HDR;
                    end
                end
                default: begin
                    n_phase = PH_BUF_HDR;
                end
            endcase

            if (seg_end) begin
                n_position     = 27'd0;
                n_phase        = PH_BUF_HDR;
                n_hdr_shift    = 24'd0;
                n_hdr_count    = 2'd0;
                n_payload_left = 32'd0;
                n_cur_offset   = 26'd0;
                n_cur_size     = 32'd0;
                n_skip_target  = 34'd0;
                n_buf_end      = 34'd0;
            end else begin
                n_position = np[26:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= 27'd0;
            r_phase        <= PH_BUF_HDR;
            r_hdr_shift    <= 24'd0;
            r_hdr_count    <= 2'd0;
            r_payload_left <= 32'd0;
            r_cur_offset   <= 26'd0;
            r_cur_size     <= 32'd0;
            r_skip_target  <= 34'd0;
            r_buf_end      <= 34'd0;
        end else begin
            r_position     <= n_position;
            r_phase        <= n_phase;
            r_hdr_shift    <= n_hdr_shift;
            r_hdr_count    <= n_hdr_count;
            r_payload_left <= n_payload_left;
            r_cur_offset   <= n_cur_offset;
            r_cur_size     <= n_cur_size;
            r_skip_target  <= n_skip_target;
            r_buf_end      <= n_buf_end;
        end
    end

    // The rounded buffer end is first needed at least four bytes after the
    // buffer end is set, so it is registered from the buffer end register.
    always_ff @(posedge i_clk) begin
        r_buf_end_rnd <= (r_buf_end + srd_pkg::BLK_MASK) & ~srd_pkg::BLK_MASK;
    end

endmodule

`default_nettype wire

// ----- design/segment_record_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Segment record deframer
// The block takes one segment byte per transaction and emits one transaction
// for every record payload byte, with the record's segment, offset and size
// and its first, last and truncated marks. It accepts one byte in every clock
// cycle while the two-entry output buffer is not full, and updates the position
// counter and framing phase with each accepted byte; the buffer lets input keep
// flowing while a result waits, and registers each result as its byte is accepted.
// The segment size register may be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_record_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [26:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0: data_byte[7:0], segment_num[27:8], zero fill.
    input  wire logic [31:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // Fields from bit 0: record_segment[19:0], record_start[45:20],
    // record_size[77:46], payload_byte[85:78], zero fill.
    output logic [87:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // Fields from bit 0: first_of_record[0], truncated[1].
    output logic [1:0]       o_m_axis_tuser
);

    logic [26:0]      r_segment_size;
    logic             in_accept;
    logic             res_valid;
    srd_pkg::t_result res;
    srd_pkg::t_result r_q [2];
    logic [1:0]       r_count, n_count;
    logic             push;
    logic             pop;
    logic [1:0]       wr_slot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_size <= 27'd131072;
        end else if (i_cfg_valid) begin
            r_segment_size <= i_cfg_data;
        end
    end

    assign o_s_axis_tready = r_count != 2'd2;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    srd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_s_axis_tdata[7:0]),
        .i_segment_num  (i_s_axis_tdata[27:8]),
        .i_segment_size (r_segment_size),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_comb begin
        push    = res_valid;
        pop     = (r_count != 2'd0) && i_m_axis_tready;
        n_count = r_count + {1'b0, push} - {1'b0, pop};
        wr_slot = r_count - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (wr_slot == 2'd0)) begin
            r_q[0] <= res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push && (wr_slot == 2'd1)) begin
            r_q[1] <= res;
        end
    end

    assign o_m_axis_tvalid = r_count != 2'd0;
    assign o_m_axis_tdata  = {2'd0, r_q[0].payload_byte, r_q[0].record_size,
                              r_q[0].record_start, r_q[0].record_segment};
    assign o_m_axis_tlast  = r_q[0].last_of_record;
    assign o_m_axis_tuser  = {r_q[0].truncated, r_q[0].first_of_record};

endmodule

`default_nettype wire

// ----- design/srd_checker.sv -----
// ----------------------------------------------------------------------------
// Segment record deframer port checker
// Checks on the top-level ports, bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_record_deframer_unit_assert.svh"

module srd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_s_axis_tready,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [87:0] o_m_axis_tdata,
    input  wire logic        o_m_axis_tlast,
    input  wire logic [1:0]  o_m_axis_tuser
);

    // A truncated transaction always closes its record.
    `SRD_ASSERT_SAME(a_trunc_is_last, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tlast, "truncated without last")

    // With nothing waiting on the output, the input side must be open.
    `SRD_ASSERT_SAME(a_empty_ready, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output")

    // A stalled output transaction keeps its payload.
    `SRD_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output changed under stall")

endmodule

bind segment_record_deframer_unit srd_checker u_srd_checker (.*);

`default_nettype wire

// ----- bench/tb_segment_record_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the segment record deframer
// Streams segment bytes into the block and follows the framing with its own
// copy of the position, phase and header state. Every payload transaction
// that the block emits is compared field by field with the oldest predicted
// one. Directed frames cover the field extremes and the truncated record.
// Random segments of many sizes carry well-formed buffers with random
// lengths, records and noise, under several idle patterns on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_record_deframer_unit;

    localparam logic [63:0] BLOCK_BYTES  = 64'd1 << srd_pkg::BLK_LOG2;
    localparam logic [63:0] RECORD_BYTES = 64'd1 << srd_pkg::REC_LOG2;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned STALL_LIMIT  = 2000;

    typedef enum logic [2:0] {
        FR_BUF_HDR,
        FR_REC_HDR,
        FR_PAYLOAD,
        FR_PAD,
        FR_SKIP
    } t_frame_phase;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [26:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] s_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    int unsigned sent_items = 0;

    // Predicted framing state.
    logic [26:0]  seg_size_m;
    logic [26:0]  pos_m;
    t_frame_phase phase_m;
    logic [31:0]  hdr_shift_m;
    int unsigned  hdr_cnt_m;
    logic [31:0]  buf_len_m;
    logic [32:0]  buf_used_m;
    logic [31:0]  left_m;
    logic [25:0]  rec_off_m;
    logic [31:0]  rec_size_m;
    logic [33:0]  skip_to_m;

    srd_pkg::t_result pending_payload[$];
    logic [7:0]       segment_bytes[$];
    srd_pkg::t_result got_r;
    srd_pkg::t_result want_r;

    segment_record_deframer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [63:0] round_to(input logic [63:0] x, input logic [63:0] a);
        return ((x + a - 64'd1) / a) * a;
    endfunction

    function automatic void clear_progress();
        phase_m     = FR_BUF_HDR;
        hdr_shift_m = '0;
        hdr_cnt_m   = 0;
        buf_len_m   = '0;
        buf_used_m  = '0;
        left_m      = '0;
        rec_off_m   = '0;
        rec_size_m  = '0;
        skip_to_m   = '0;
    endfunction

    function automatic void close_buffer(input logic [63:0] np);
        logic [63:0] rem;
        logic [63:0] tgt;
        rem = (64'(buf_used_m) < 64'(buf_len_m)) ? 64'(buf_len_m) - 64'(buf_used_m) : 64'd0;
        tgt = round_to(np + rem, BLOCK_BYTES);
        if (tgt == np) begin
            phase_m = FR_BUF_HDR;
        end else begin
            skip_to_m = tgt[33:0];
            phase_m   = FR_SKIP;
        end
    endfunction

    function automatic void next_record(input logic [63:0] np);
        if (64'(buf_used_m) < 64'(buf_len_m)) begin
            phase_m = FR_REC_HDR;
        end else begin
            close_buffer(np);
        end
    endfunction

    function automatic logic gather_header(input logic [7:0] b);
        hdr_shift_m = hdr_shift_m | (32'(b) << (8 * (hdr_cnt_m & 3)));
        hdr_cnt_m++;
        return hdr_cnt_m >= 4;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic [19:0] seg);
        logic [63:0]      np;
        logic [63:0]      tgt;
        logic [31:0]      word;
        logic             seg_end;
        logic             first;
        logic             last;
        logic             trunc;
        srd_pkg::t_result r;
        np      = 64'(pos_m) + 64'd1;
        seg_end = np >= 64'(seg_size_m);
        case (phase_m)
            FR_BUF_HDR: begin
                if (gather_header(b)) begin
                    word        = hdr_shift_m;
                    hdr_shift_m = '0;
                    hdr_cnt_m   = 0;
                    if (word == 0) begin
                        tgt       = round_to(np, BLOCK_BYTES);
                        skip_to_m = tgt[33:0];
                        phase_m   = (tgt == np) ? FR_BUF_HDR : FR_SKIP;
                    end else begin
                        buf_len_m  = word;
                        buf_used_m = '0;
                        phase_m    = FR_REC_HDR;
                    end
                end
            end
            FR_REC_HDR: begin
                if (gather_header(b)) begin
                    word        = hdr_shift_m;
                    hdr_shift_m = '0;
                    hdr_cnt_m   = 0;
                    buf_used_m  = buf_used_m + 33'd4;
                    if (word == 0) begin
                        close_buffer(np);
                    end else begin
                        rec_off_m  = np[25:0];
                        rec_size_m = word;
                        left_m     = word;
                        phase_m    = FR_PAYLOAD;
                    end
                end
            end
            FR_PAYLOAD: begin
                first  = (left_m == rec_size_m);
                left_m = left_m - 32'd1;
                last   = (left_m == 0);
                trunc  = !last && seg_end;
                r.record_segment  = seg;
                r.record_start    = rec_off_m;
                r.record_size     = rec_size_m;
                r.payload_byte    = b;
                r.first_of_record = first;
                r.last_of_record  = last || trunc;
                r.truncated       = trunc;
                pending_payload.insert(pending_payload.size(), r);
                if (last) begin
                    tgt        = round_to(np, RECORD_BYTES);
                    buf_used_m = 33'(64'(buf_used_m) + 64'(rec_size_m) + (tgt - np));
                    if (tgt == np) begin
                        next_record(np);
                    end else begin
                        skip_to_m = tgt[33:0];
                        phase_m   = FR_PAD;
                    end
                end
            end
            FR_PAD: begin
                if (np == 64'(skip_to_m)) begin
                    next_record(np);
                end
            end
            default: begin
                if (np == 64'(skip_to_m)) begin
                    phase_m = FR_BUF_HDR;
                end
            end
        endcase
        if (seg_end) begin
            pos_m = '0;
            clear_progress();
        end else begin
            pos_m = np[26:0];
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [19:0] seg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, seg, b};
        do @(posedge clk); while (!o_s_axis_tready);
        sent_items++;
        deframe_byte(b, seg);
    endtask

    // Stops the sender until every predicted payload transaction has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_payload.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_segment_size(input logic [26:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        seg_size_m = value;
    endtask

    function automatic void put_le32(input logic [31:0] w);
        int k;
        for (k = 0; k < 4; k++) begin
            segment_bytes.insert(segment_bytes.size(), w[8*k +: 8]);
        end
    endfunction

    // Builds buffers at block boundaries from the current position up to the
    // segment end, or up to cap bytes, and streams them.
    task automatic run_segment(input logic [19:0] seg, input longint unsigned cap);
        longint unsigned base;
        longint unsigned total;
        longint unsigned len;
        longint unsigned used;
        longint unsigned size;
        longint unsigned k;
        int unsigned     pick;
        base  = 64'(pos_m);
        total = (seg_size_m > pos_m) ? 64'(seg_size_m - pos_m) : 64'd1;
        if (total > cap) begin
            total = cap;
        end
        segment_bytes.delete();
        while (segment_bytes.size() < total) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                len = 0;
            end else if (pick < 13) begin
                len = 64'($urandom());
            end else begin
                len = 64'($urandom_range(300, 8));
            end
            put_le32(len[31:0]);
            used = 0;
            while (len != 0 && used < len && segment_bytes.size() < total) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    size = 0;
                end else if (pick < 9) begin
                    size = 64'($urandom());
                end else if (pick < 14) begin
                    size = 64'($urandom_range(400, 60));
                end else begin
                    size = 64'($urandom_range(24, 1));
                end
                put_le32(size[31:0]);
                used += 4;
                if (size == 0) begin
                    break;
                end
                for (k = 0; k < size && segment_bytes.size() < total; k++) begin
                    segment_bytes.insert(segment_bytes.size(), 8'($urandom));
                end
                used += size;
                while ((base + 64'(segment_bytes.size())) % RECORD_BYTES != 0 &&
                       segment_bytes.size() < total) begin
                    segment_bytes.insert(segment_bytes.size(), 8'($urandom));
                    used++;
                end
            end
            while ((base + 64'(segment_bytes.size())) % BLOCK_BYTES != 0 &&
                   segment_bytes.size() < total) begin
                segment_bytes.insert(segment_bytes.size(), 8'($urandom));
            end
        end
        for (k = 0; k < total; k++) begin
            send_byte(segment_bytes[k], seg);
        end
    endtask

    // Maximum buffer length, a short record with padding, then a record of
    // maximum size that the segment end cuts off.
    task automatic test_directed_frame();
        logic [7:0] frame [24];
        int         k;
        frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h81, 8'h7E,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F};
        write_segment_size(27'd24);
        for (k = 0; k < 24; k++) begin
            send_byte(frame[k], 20'hFFFFF);
        end
    endtask

    // A segment size of zero wraps after every byte.
    task automatic test_zero_segment_size();
        write_segment_size(27'd0);
        send_byte(8'h00, 20'h00000);
        send_byte(8'h80, 20'h00000);
        send_byte(8'h7F, 20'h00000);
    endtask

    task automatic test_random_segments(input int unsigned send_pct,
                                        input int unsigned recv_pct,
                                        input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        logic [26:0] size;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = sent_items;
        while (sent_items - start < quota) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                size = 27'($urandom_range(600, 16));
            end else if (pick < 64) begin
                size = 27'($urandom_range(15, 1));
            end else if (pick < 70) begin
                size = 27'd0;
            end else if (pick < 88) begin
                size = 27'(BLOCK_BYTES);
            end else begin
                size = 27'(BLOCK_BYTES * 64'($urandom_range(3, 2)));
            end
            if ($urandom_range(2) != 0) begin
                write_segment_size(size);
            end else if ($urandom_range(3) == 0) begin
                drain_results();
            end
            run_segment(20'($urandom), 64'(quota - (sent_items - start)));
        end
    endtask

    // The largest sizes are only entered briefly; a size of one then forces
    // the wrap back to the start of a segment.
    task automatic test_large_segments();
        write_segment_size(27'd67108864);
        run_segment(20'($urandom), 64'd24);
        write_segment_size(27'h7FFFFFF);
        run_segment(20'($urandom), 64'd16);
        write_segment_size(27'd1);
        run_segment(20'($urandom), 64'd1);
        write_segment_size(27'(BLOCK_BYTES));
        run_segment(20'($urandom), 64'd8);
    endtask

    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got_r.record_segment  = o_m_axis_tdata[19:0];
            got_r.record_start    = o_m_axis_tdata[45:20];
            got_r.record_size     = o_m_axis_tdata[77:46];
            got_r.payload_byte    = o_m_axis_tdata[85:78];
            got_r.first_of_record = o_m_axis_tuser[0];
            got_r.last_of_record  = o_m_axis_tlast;
            got_r.truncated       = o_m_axis_tuser[1];
            if (pending_payload.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected transaction: seg=%h off=%h size=%h byte=%h",
                             got_r.record_segment, got_r.record_start,
                             got_r.record_size, got_r.payload_byte);
                end
            end else begin
                want_r = pending_payload.pop_front();
                if (got_r.record_segment !== want_r.record_segment ||
                    got_r.record_start !== want_r.record_start ||
                    got_r.record_size !== want_r.record_size ||
                    got_r.payload_byte !== want_r.payload_byte ||
                    got_r.first_of_record !== want_r.first_of_record ||
                    got_r.last_of_record !== want_r.last_of_record ||
                    got_r.truncated !== want_r.truncated) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Expected: seg=%h off=%h size=%h byte=%h flt=%b%b%b",
                                 want_r.record_segment, want_r.record_start,
                                 want_r.record_size, want_r.payload_byte,
                                 want_r.first_of_record, want_r.last_of_record,
                                 want_r.truncated);
                        $display("Actual:   seg=%h off=%h size=%h byte=%h flt=%b%b%b",
                                 got_r.record_segment, got_r.record_start,
                                 got_r.record_size, got_r.payload_byte,
                                 got_r.first_of_record, got_r.last_of_record,
                                 got_r.truncated);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        seg_size_m = 27'd131072;
        pos_m      = '0;
        clear_progress();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_frame();
        test_zero_segment_size();
        test_random_segments(13, 64, 110);
        test_random_segments(64, 13, 110);
        test_random_segments(0, 0, 110);
        test_large_segments();
        drain_results();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
